FILE: rtl/prs_pkg.sv
`timescale 1ns / 1ps

package prs_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned LEN_W  = 16;

	localparam logic [LEN_W-1:0]  HEADER_BYTES = 16'd20;
	localparam logic [WORD_W-1:0] RESET_MAGIC  = 32'h4F54_4650;
	localparam logic [WORD_W-1:0] RESET_IDLE   = 32'd2000;
	localparam logic [WORD_W-1:0] RESET_EMPTY  = 32'd45000;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EMPTY = 2'd2;

	// Item kinds carried on tuser
	localparam logic ACT_DATAGRAM = 1'b0;
	localparam logic ACT_TICK     = 1'b1;

	typedef struct packed {
		logic              action;
		logic              fin;
		logic [WORD_W-1:0] now_ms;
		logic [LEN_W-1:0]  payload_length;
		logic [WORD_W-1:0] magic_word;
		logic [WORD_W-1:0] sequence_req;
		logic [WORD_W-1:0] sender_time_ms;
		logic [WORD_W-1:0] run_total;
	} item_t;

	typedef struct packed {
		logic [WORD_W-1:0] expected_magic;
		logic [WORD_W-1:0] idle_timeout_ms;
		logic [WORD_W-1:0] empty_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic              done_flag;
		logic [WORD_W-1:0] planned_total;
		logic [WORD_W-1:0] packets;
		logic [WORD_W-1:0] bytes;
		logic [WORD_W-1:0] highest_sequence;
		logic [WORD_W-1:0] reorders;
		logic [WORD_W-1:0] duplicate_fins;
		logic [WORD_W-1:0] bad_headers;
		logic [WORD_W-1:0] first_arrival;
		logic [WORD_W-1:0] last_arrival;
		logic [WORD_W-1:0] last_sender_time;
		logic [WORD_W-1:0] last_activity;
		logic [WORD_W-1:0] delay_minimum;
		logic [WORD_W-1:0] delay_maximum;
		logic              have_delay;
	} state_t;

	typedef struct packed {
		logic                     run_done;
		logic [WORD_W-1:0]        packet_count;
		logic [WORD_W-1:0]        byte_count;
		logic [WORD_W-1:0]        expected_count;
		logic [WORD_W-1:0]        lost_count;
		logic [WORD_W-1:0]        reorder_count;
		logic [WORD_W-1:0]        duplicate_fin_count;
		logic [WORD_W-1:0]        bad_header_count;
		logic signed [WORD_W-1:0] delay_spread_ms;
		logic [WORD_W-1:0]        duration_ms;
		logic [WORD_W-1:0]        tail_ms;
	} report_t;

	// Two's complement less-than on raw words.
	function automatic logic signed_less(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
		return $signed(a) < $signed(b);
	endfunction

endpackage

FILE: rtl/probe_receive_statistics_unit.sv
`timescale 1ns / 1ps

// Throughput-probe receive statistics. Each slave beat is either a datagram header
// (tuser low) or a time tick (tuser high); every beat yields exactly one report beat
// carrying the running counts, expected and lost packets, delay spread, run duration
// and tail time, with tlast showing that the run has finished. The unit takes one
// beat per cycle unless the report output stalls; a report passes through the input
// register, the state update register and the report output register. Writes
// on the configuration channel are always taken and should be made while no beats
// are in flight.
module probe_receive_statistics_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// now_ms, payload_length, magic_word, sequence_req, sender_time_ms, run_total
	input  logic [175:0] s_axis_tdata,
	// action
	input  logic         s_axis_tuser,
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// packet_count, byte_count, expected_count, lost_count, reorder_count,
	// duplicate_fin_count, bad_header_count, delay_spread_ms, duration_ms, tail_ms
	output logic [319:0] m_axis_tdata,
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [prs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [prs_pkg::WORD_W-1:0]    cfg_data
);

	prs_pkg::cfg_t    cfg_q;
	prs_pkg::item_t   item_in;
	prs_pkg::item_t   item_s1;
	prs_pkg::state_t  state;
	prs_pkg::report_t report;
	logic             s1_valid_q;
	logic             rpt_valid_q;
	logic             rpt_ready;
	logic             s1_go;
	logic             s_accept;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_magic   <= prs_pkg::RESET_MAGIC;
			cfg_q.idle_timeout_ms  <= prs_pkg::RESET_IDLE;
			cfg_q.empty_timeout_ms <= prs_pkg::RESET_EMPTY;
		end else if (cfg_valid) begin
			case (cfg_index)
				prs_pkg::CFG_MAGIC: cfg_q.expected_magic   <= cfg_data;
				prs_pkg::CFG_IDLE:  cfg_q.idle_timeout_ms  <= cfg_data;
				prs_pkg::CFG_EMPTY: cfg_q.empty_timeout_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	assign item_in.action         = s_axis_tuser;
	assign item_in.fin            = s_axis_tlast;
	assign item_in.now_ms         = s_axis_tdata[31:0];
	assign item_in.payload_length = s_axis_tdata[47:32];
	assign item_in.magic_word     = s_axis_tdata[79:48];
	assign item_in.sequence_req   = s_axis_tdata[111:80];
	assign item_in.sender_time_ms = s_axis_tdata[143:112];
	assign item_in.run_total      = s_axis_tdata[175:144];

	// The state may only move on once the report of the previous beat has left.
	assign s1_go         = s1_valid_q && (!rpt_valid_q || rpt_ready);
	assign s_axis_tready = !s1_valid_q || s1_go;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rpt_valid_q <= 1'b0;
		end else begin
			if (s_accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_go) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_go) begin
				rpt_valid_q <= 1'b1;
			end else if (rpt_ready) begin
				rpt_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1 <= item_in;
		end
	end

	prs_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.upd_en (s1_go),
		.item   (item_s1),
		.cfg    (cfg_q),
		.state  (state)
	);

	prs_report u_report (
		.clk       (clk),
		.arst_n    (arst_n),
		.state     (state),
		.rpt_valid (rpt_valid_q),
		.rpt_ready (rpt_ready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.report    (report)
	);

	assign m_axis_tlast = report.run_done;
	assign m_axis_tdata = {report.tail_ms, report.duration_ms, report.delay_spread_ms,
	                       report.bad_header_count, report.duplicate_fin_count,
	                       report.reorder_count, report.lost_count, report.expected_count,
	                       report.byte_count, report.packet_count};

endmodule

FILE: rtl/prs_state.sv
`timescale 1ns / 1ps

module prs_state (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            upd_en,
	input  prs_pkg::item_t  item,
	input  prs_pkg::cfg_t   cfg,
	output prs_pkg::state_t state
);

	prs_pkg::state_t state_q;
	prs_pkg::state_t state_nxt;

	logic [prs_pkg::WORD_W-1:0] delay;
	logic [prs_pkg::WORD_W-1:0] since_arrival;
	logic [prs_pkg::WORD_W-1:0] since_activity;
	logic                       bad_header;

	assign delay          = item.now_ms - item.sender_time_ms;
	assign since_arrival  = item.now_ms - state_q.last_arrival;
	assign since_activity = item.now_ms - state_q.last_activity;
	assign bad_header     = (item.payload_length < prs_pkg::HEADER_BYTES) ||
	                        (item.magic_word != cfg.expected_magic);

	always_comb begin
		state_nxt = state_q;
		if (item.action == prs_pkg::ACT_DATAGRAM) begin
			if (bad_header) begin
				// A bad header touches nothing else, not even the activity time.
				state_nxt.bad_headers = state_q.bad_headers + 32'd1;
			end else if (item.fin) begin
				state_nxt.planned_total = item.run_total;
				state_nxt.last_activity = item.now_ms;
				if (!state_q.done_flag) begin
					state_nxt.done_flag = 1'b1;
				end else begin
					state_nxt.duplicate_fins = state_q.duplicate_fins + 32'd1;
				end
			end else begin
				state_nxt.planned_total = item.run_total;
				if (state_q.packets == '0) begin
					state_nxt.first_arrival = item.now_ms;
					state_nxt.done_flag     = 1'b0;
				end
				state_nxt.packets          = state_q.packets + 32'd1;
				state_nxt.bytes            = state_q.bytes + {16'd0, item.payload_length};
				state_nxt.last_arrival     = item.now_ms;
				state_nxt.last_sender_time = item.sender_time_ms;
				state_nxt.last_activity    = item.now_ms;
				if (item.sequence_req >= state_q.highest_sequence) begin
					state_nxt.highest_sequence = item.sequence_req;
				end else begin
					state_nxt.reorders = state_q.reorders + 32'd1;
				end
				if (!state_q.have_delay) begin
					state_nxt.have_delay    = 1'b1;
					state_nxt.delay_minimum = delay;
					state_nxt.delay_maximum = delay;
				end else if (prs_pkg::signed_less(delay, state_q.delay_minimum)) begin
					state_nxt.delay_minimum = delay;
				end else if (prs_pkg::signed_less(state_q.delay_maximum, delay)) begin
					state_nxt.delay_maximum = delay;
				end
			end
		end else if (!state_q.done_flag) begin
			if (state_q.packets != '0) begin
				if (since_arrival > cfg.idle_timeout_ms) begin
					state_nxt.done_flag = 1'b1;
				end
			end else if (since_activity > cfg.empty_timeout_ms) begin
				state_nxt.done_flag = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (upd_en) begin
			state_q <= state_nxt;
		end
	end

	assign state = state_q;

	a_packets_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.packets != $past(state_q.packets)) |->
		(state_q.packets == $past(state_q.packets) + 32'd1))
		else $error("packet count moved by other than one");

	a_delay_before_packets: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.have_delay |-> (state_q.packets == '0))
		else $error("packets counted without a delay sample");

	a_delay_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.have_delay |->
		!prs_pkg::signed_less(state_q.delay_maximum, state_q.delay_minimum))
		else $error("delay maximum below minimum");

	a_done_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q.done_flag) |-> $past(upd_en))
		else $error("run finished without an item");

endmodule

FILE: rtl/prs_report.sv
`timescale 1ns / 1ps

module prs_report (
	input  logic            clk,
	input  logic            arst_n,
	input  prs_pkg::state_t state,
	input  logic            rpt_valid,
	output logic            rpt_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output prs_pkg::report_t report
);

	prs_pkg::report_t rpt;
	prs_pkg::report_t report_q;
	logic             out_valid_q;
	logic [prs_pkg::WORD_W-1:0] span;

	assign span = state.last_arrival - state.first_arrival;

	always_comb begin
		rpt                     = '0;
		rpt.run_done            = state.done_flag;
		rpt.packet_count        = state.packets;
		rpt.byte_count          = state.bytes;
		rpt.reorder_count       = state.reorders;
		rpt.duplicate_fin_count = state.duplicate_fins;
		rpt.bad_header_count    = state.bad_headers;
		if (state.planned_total != '0) begin
			rpt.expected_count = state.planned_total;
		end else if (state.packets != '0) begin
			rpt.expected_count = state.highest_sequence + 32'd1;
		end
		if (rpt.expected_count > state.packets) begin
			rpt.lost_count = rpt.expected_count - state.packets;
		end
		if (state.have_delay) begin
			rpt.delay_spread_ms = $signed(state.delay_maximum - state.delay_minimum);
		end
		if (state.packets != '0) begin
			// A reversed or zero span still reports one millisecond.
			if ((state.last_arrival >= state.first_arrival) && (span != '0)) begin
				rpt.duration_ms = span;
			end else begin
				rpt.duration_ms = 32'd1;
			end
			if (state.last_arrival >= state.last_sender_time) begin
				rpt.tail_ms = state.last_arrival - state.last_sender_time;
			end
		end
	end

	assign rpt_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rpt_valid && rpt_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rpt_valid && rpt_ready) begin
			report_q <= rpt;
		end
	end

	assign out_valid = out_valid_q;
	assign report    = report_q;

endmodule
